>>> design/rspc_pkg.sv
// Shared types and constants for the range scale power curve block.
// No dependencies; imported by every module of the block.
package rspc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_IN_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE    = 3'd4;

  // Table kinds for the ROM module
  localparam int ROM_LOG = 0;
  localparam int ROM_EXP = 1;

  // Fixed widths
  localparam int SMP_W  = 32;   // Q16.16 samples and range ends
  localparam int CRV_W  = 16;   // Q8.8 curve exponent
  localparam int EXP_W  = 31;   // exp2 table entries, Q30
  localparam int DLT_W  = 35;   // clipped delta, up to 2^34

  // Per item control that travels with the data
  typedef struct packed {
    logic vld;     // stage holds an item
    logic dzero;   // input span is zero
    logic nzero;   // sample equals in_low
    logic neg;     // position is negative
  } side_t;

endpackage

>>> design/rspc_rom.sv
// Constant lookup table with registered read: log2 mantissa or exp2 fraction.
// Depends on rspc_pkg; contents are built at elaboration.
module rspc_rom #(
  parameter int AW   = 10,
  parameter int DW   = 17,
  parameter int KIND = 0,
  parameter int FB   = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] addr,
  output logic [DW-1:0] q
);
  import rspc_pkg::*;

  localparam int DEPTH = 1 << AW;
  typedef logic [DW-1:0] rom_arr_t [DEPTH];

  // floor square root of a 64-bit value
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int bt = 31; bt >= 0; bt--) begin
      t = r | (64'd1 << bt);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // log2(1 + i/2^AW) with FB fractional bits
  function automatic logic [63:0] log_entry(input int i);
    logic [63:0] x;
    logic [63:0] r;
    x = ((64'd1 << AW) + 64'(i)) << (30 - AW);
    r = '0;
    for (int k = 1; k <= 30; k++) begin
      x = (x * x + (64'd1 << 29)) >> 30;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        r = r | (64'd1 << (30 - k));
      end
    end
    return (r + (64'd1 << (29 - FB))) >> (30 - FB);
  endfunction

  // 2^(j/2^AW) in Q30
  function automatic logic [63:0] exp_entry(input int j);
    logic [63:0] c [16];
    logic [63:0] v;
    for (int k = 0; k < 16; k++) c[k] = '0;
    c[1] = isqrt64(64'd1 << 61);
    for (int k = 2; k <= AW; k++) c[k] = isqrt64(c[k-1] << 30);
    v = 64'd1 << 30;
    for (int k = 0; k < AW; k++) begin
      if (((j >> k) & 1) != 0) v = (v * c[AW-k] + (64'd1 << 29)) >> 30;
    end
    return v;
  endfunction

  function automatic rom_arr_t build_rom();
    rom_arr_t    t;
    logic [63:0] v;
    for (int i = 0; i < DEPTH; i++) begin
      v = (KIND == ROM_LOG) ? log_entry(i) : exp_entry(i);
      t[i] = v[DW-1:0];
    end
    return t;
  endfunction

  localparam rom_arr_t ROM = build_rom();

  logic [DW-1:0] q_r;

  // registered read, held while the pipeline stalls
  always_ff @(posedge clk) begin
    if (en) q_r <= ROM[addr];
  end

  assign q = q_r;

endmodule

>>> design/rspc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on rspc_pkg for the side_t control struct.
module rspc_div #(
  parameter int QW = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  rspc_pkg::side_t      in_side,
  input  logic [QW-1:0]        in_dvd,
  input  logic [31:0]          den,
  output rspc_pkg::side_t      out_side,
  output logic [QW-1:0]        out_quo
);
  import rspc_pkg::*;

  logic [31:0]   rem_r  [QW];
  logic [QW-1:0] dq_r   [QW];
  side_t         side_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [31:0]   rem_in;
    logic [QW-1:0] dq_in;
    side_t         sd_in;
    logic [32:0]   trial;
    logic          ge;
    logic [31:0]   rem_nxt;
    logic [QW-1:0] dq_nxt;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = in_dvd;
      assign sd_in  = in_side;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign dq_in  = dq_r[i-1];
      assign sd_in  = side_r[i-1];
    end

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
      trial   = {rem_in, dq_in[QW-1]};
      ge      = (trial >= {1'b0, den});
      rem_nxt = ge ? 32'(trial - {1'b0, den}) : trial[31:0];
      dq_nxt  = {dq_in[QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[i] <= '0;
      end else if (adv) begin
        side_r[i] <= sd_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i] <= rem_nxt;
        dq_r[i]  <= dq_nxt;
      end
    end
  end

  assign out_side = side_r[QW-1];
  assign out_quo  = dq_r[QW-1];

endmodule

>>> design/rspc_norm.sv
// Staged leading-one normalizer: one power-of-two shift decision per stage.
// Depends on rspc_pkg for the side_t control struct.
module rspc_norm #(
  parameter int QW = 48
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  rspc_pkg::side_t         in_side,
  input  logic [QW-1:0]           in_x,
  output rspc_pkg::side_t         out_side,
  output logic [QW-1:0]           out_x,
  output logic [$clog2(QW)-1:0]   out_lz
);
  import rspc_pkg::*;

  localparam int NS = $clog2(QW);

  logic [QW-1:0] x_r    [NS];
  logic [NS-1:0] lz_r   [NS];
  side_t         side_r [NS];

  // a quotient below resolution counts as one LSB
  logic [QW-1:0] x_first;
  assign x_first = (in_x == '0) ? QW'(1) : in_x;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int SH = 1 << (NS - 1 - k);
    logic [QW-1:0] x_in;
    logic [NS-1:0] lz_in;
    side_t         sd_in;
    logic          hit;
    logic [QW-1:0] x_nxt;
    logic [NS-1:0] lz_nxt;

    if (k == 0) begin : g_first
      assign x_in  = x_first;
      assign lz_in = '0;
      assign sd_in = in_side;
    end else begin : g_next
      assign x_in  = x_r[k-1];
      assign lz_in = lz_r[k-1];
      assign sd_in = side_r[k-1];
    end

    // shift left when the top SH bits are all zero
    always_comb begin
      hit    = (x_in[QW-1 -: SH] == '0);
      x_nxt  = hit ? (x_in << SH) : x_in;
      lz_nxt = hit ? (lz_in + NS'(SH)) : lz_in;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k] <= '0;
      end else if (adv) begin
        side_r[k] <= sd_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[k]  <= x_nxt;
        lz_r[k] <= lz_nxt;
      end
    end
  end

  assign out_side = side_r[NS-1];
  assign out_x    = x_r[NS-1];
  assign out_lz   = lz_r[NS-1];

endmodule

>>> design/range_scale_power_curve.sv
// Top level of the range scale power curve block: config, position, log/exp
// power and output scaling. Depends on rspc_pkg, rspc_div, rspc_norm, rspc_rom.
//
//   channel   direction  handshake           payload
//   in_       input      in_valid/in_stall   in_sample
//   out_      output     out_valid/out_stall out_scaled, out_saturated
//   cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item per cycle while in_stall is low. Stages: 1 input stage, 32+FRAC_BITS
// divider stages (one quotient bit each), clog2(32+FRAC_BITS) normalizer stages,
// 8 power/scale stages, output register.
// Reset is synchronous, clears all valid bits and the config and span registers; no clearing pass.
// A one-item skid buffer behind the output register absorbs out_stall; in_stall
// is high only while that buffer is full, and the whole pipeline holds then.
module range_scale_power_curve #(
  parameter int LOG_TABLE_BITS = 10,
  parameter int FRAC_BITS      = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [31:0]              in_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [31:0]              out_scaled,
  output logic                            out_saturated,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rspc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data
);
  import rspc_pkg::*;

  localparam int L   = LOG_TABLE_BITS;
  localparam int F   = FRAC_BITS;
  localparam int QW  = 32 + F;
  localparam int NS  = $clog2(QW);
  localparam int EW  = 8;
  localparam int LGW = F + 7;
  localparam int PW  = F + 23;
  localparam int PPW = PW - 8;
  localparam int NW  = 16;
  localparam int SW  = 17;
  localparam int MW  = 63;

  // ---------------- configuration registers ----------------
  logic signed [31:0] in_low_r, in_high_r, out_low_r, out_high_r;
  logic signed [15:0] curve_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_low_r   <= '0;
      in_high_r  <= '0;
      out_low_r  <= '0;
      out_high_r <= '0;
      curve_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IN_LOW:   in_low_r   <= cfg_data;
        REG_IN_HIGH:  in_high_r  <= cfg_data;
        REG_OUT_LOW:  out_low_r  <= cfg_data;
        REG_OUT_HIGH: out_high_r <= cfg_data;
        REG_CURVE:    curve_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // spans derived from the registers, refreshed every cycle
  logic signed [32:0] dspan, ospan;
  logic               span_neg_r;
  logic [31:0]        b_r, mag_r;

  assign dspan = 33'(in_high_r) - 33'(in_low_r);
  assign ospan = 33'(out_high_r) - 33'(out_low_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r        <= '0;
      span_neg_r <= 1'b0;
      mag_r      <= '0;
    end else begin
      b_r        <= dspan[32] ? 32'(-dspan) : dspan[31:0];
      span_neg_r <= ospan[32];
      mag_r      <= ospan[32] ? 32'(-ospan) : ospan[31:0];
    end
  end

  // ---------------- flow control ----------------
  logic adv;
  logic skid_full_r;

  assign adv      = !skid_full_r;
  assign in_stall = skid_full_r;

  // ---------------- stage 0: position numerator ----------------
  logic signed [32:0] num;
  side_t              sd0_nxt, sd0_r;
  logic [31:0]        a_r;

  assign num = 33'(in_sample) - 33'(in_low_r);

  // span flags come straight from the registers so a fresh write counts
  always_comb begin
    sd0_nxt.vld   = in_valid;
    sd0_nxt.dzero = (dspan == '0);
    sd0_nxt.nzero = (num == '0);
    sd0_nxt.neg   = num[32] != dspan[32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd0_r <= '0;
    end else if (adv) begin
      sd0_r <= sd0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) a_r <= num[32] ? 32'(-num) : num[31:0];
  end

  // ---------------- divider and normalizer ----------------
  side_t            sd_div, sd_nrm;
  logic [QW-1:0]    quo, nx;
  logic [NS-1:0]    nlz;

  rspc_div #(.QW(QW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_side  (sd0_r),
    .in_dvd   ({a_r, {F{1'b0}}}),
    .den      (b_r),
    .out_side (sd_div),
    .out_quo  (quo)
  );

  rspc_norm #(.QW(QW)) u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_side  (sd_div),
    .in_x     (quo),
    .out_side (sd_nrm),
    .out_x    (nx),
    .out_lz   (nlz)
  );

  // ---------------- T1: log table index, log ROM read ----------------
  logic signed [EW-1:0] e0, e1_nxt, e1_r;
  logic [L+1:0]         idx_sum;
  logic                 idx_wrap;
  logic [L-1:0]         log_addr;
  logic [F:0]           log_q;
  side_t                sd1_r;

  always_comb begin
    e0       = EW'(QW - 1) - EW'(nlz);
    idx_sum  = {1'b0, nx[QW-2 -: L+1]} + (L+2)'(1);
    idx_wrap = idx_sum[L+1];
    log_addr = idx_wrap ? '0 : idx_sum[L:1];
    e1_nxt   = e0 + EW'(idx_wrap);
  end

  rspc_rom #(.AW(L), .DW(F+1), .KIND(ROM_LOG), .FB(F)) u_log_rom (
    .clk  (clk),
    .en   (adv),
    .addr (log_addr),
    .q    (log_q)
  );

  // ---------------- T2: log2 of the position ----------------
  logic signed [LGW-1:0] lg_nxt, lg_r;
  side_t                 sd2_r;

  assign lg_nxt = ((LGW'(e1_r) - LGW'(F)) <<< F) + LGW'({1'b0, log_q});

  // ---------------- T3: curve times log ----------------
  logic signed [PW-1:0] prod_nxt, prod_r;
  side_t                sd3_r;

  assign prod_nxt = PW'(curve_r) * PW'(lg_r);

  // ---------------- T4: split power, exp ROM read ----------------
  logic signed [PW-1:0]    prod_rnd;
  logic signed [PPW-1:0]   pw;
  logic signed [PPW-F-1:0] n0;
  logic [F-1:0]            pf;
  logic [L:0]              jfull;
  logic                    j_wrap;
  logic [L-1:0]            exp_addr;
  logic signed [NW-1:0]    n_nxt, n_r;
  logic [EXP_W-1:0]        exp_q;
  side_t                   sd4_r;

  always_comb begin
    prod_rnd = prod_r + PW'(128);
    pw       = PPW'(prod_rnd >>> 8);
    n0       = pw[PPW-1:F];
    pf       = pw[F-1:0];
  end

  if (F >= L) begin : g_jround
    localparam int HALF = (F > L) ? (1 << (F - L - 1)) : 0;
    logic [F:0] fr;
    assign fr    = {1'b0, pf} + (F+1)'(HALF);
    assign jfull = fr[F -: L+1];
  end else begin : g_jwiden
    assign jfull = {1'b0, pf, {(L-F){1'b0}}};
  end

  always_comb begin
    j_wrap   = jfull[L];
    exp_addr = j_wrap ? '0 : jfull[L-1:0];
    n_nxt    = NW'(n0) + NW'(j_wrap);
  end

  rspc_rom #(.AW(L), .DW(EXP_W), .KIND(ROM_EXP), .FB(F)) u_exp_rom (
    .clk  (clk),
    .en   (adv),
    .addr (exp_addr),
    .q    (exp_q)
  );

  // ---------------- T5: span times power mantissa ----------------
  logic [MW-1:0]        m_nxt, m_r;
  logic signed [SW-1:0] s_nxt, s_r;
  side_t                sd5_r;

  assign m_nxt = MW'(mag_r * exp_q);
  assign s_nxt = SW'(n_r) - SW'(30);

  // ---------------- T6: scale by 2^s ----------------
  logic [MW-1:0]        shv_nxt, shv_r;
  logic                 rb_nxt, rb_r, fmax_nxt, fmax_r, fzero_nxt, fzero_r;
  logic [97:0]          wide;
  logic signed [SW-1:0] sneg;
  logic [5:0]           sh6;
  side_t                sd6_r;

  always_comb begin
    wide      = {35'd0, m_r} << s_r[5:0];
    sneg      = -s_r;
    sh6       = sneg[5:0];
    shv_nxt   = '0;
    rb_nxt    = 1'b0;
    fmax_nxt  = 1'b0;
    fzero_nxt = 1'b0;
    if (!s_r[SW-1]) begin
      if (m_r == '0) begin
        fzero_nxt = 1'b1;
      end else if (s_r > SW'(34)) begin
        fmax_nxt = 1'b1;
      end else begin
        fmax_nxt = (|wide[97:35]) || (wide[34] && (|wide[33:0]));
        shv_nxt  = MW'(wide[34:0]);
      end
    end else if (sneg >= SW'(64)) begin
      fzero_nxt = 1'b1;
    end else begin
      shv_nxt = m_r >> sh6;
      rb_nxt  = m_r[sh6 - 6'd1];
    end
  end

  // ---------------- T7: round and clip delta ----------------
  logic [MW:0]        dsum;
  logic [DLT_W-1:0]   delta_nxt, delta_r;
  side_t              sd7_r;

  always_comb begin
    dsum = {1'b0, shv_r} + (MW+1)'(rb_r);
    if (fzero_r) begin
      delta_nxt = '0;
    end else if (fmax_r || (dsum > (MW+1)'(64'd1 << 34))) begin
      delta_nxt = DLT_W'(64'd1 << 34);
    end else begin
      delta_nxt = dsum[DLT_W-1:0];
    end
  end

  // ---------------- T8: apply to out_low and saturate ----------------
  logic signed [35:0] rsum;
  logic signed [31:0] res_nxt, res_r;
  logic               sat_nxt, sat_r;
  logic               vres_r;

  always_comb begin
    if (span_neg_r != sd7_r.neg) rsum = 36'(out_low_r) - 36'({1'b0, delta_r});
    else                         rsum = 36'(out_low_r) + 36'({1'b0, delta_r});
    sat_nxt = 1'b0;
    res_nxt = rsum[31:0];
    priority if (sd7_r.dzero) begin
      res_nxt = '0;
    end else if (sd7_r.nzero) begin
      res_nxt = out_low_r;
    end else if (rsum > 36'sh0_7FFF_FFFF) begin
      res_nxt = 32'sh7FFF_FFFF;
      sat_nxt = 1'b1;
    end else if (rsum < -36'sh0_8000_0000) begin
      res_nxt = 32'sh8000_0000;
      sat_nxt = 1'b1;
    end else begin
      res_nxt = rsum[31:0];
    end
  end

  // ---------------- stage registers T1..T8 ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd1_r  <= '0;
      sd2_r  <= '0;
      sd3_r  <= '0;
      sd4_r  <= '0;
      sd5_r  <= '0;
      sd6_r  <= '0;
      sd7_r  <= '0;
      vres_r <= 1'b0;
    end else if (adv) begin
      sd1_r  <= sd_nrm;
      sd2_r  <= sd1_r;
      sd3_r  <= sd2_r;
      sd4_r  <= sd3_r;
      sd5_r  <= sd4_r;
      sd6_r  <= sd5_r;
      sd7_r  <= sd6_r;
      vres_r <= sd7_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r    <= e1_nxt;
      lg_r    <= lg_nxt;
      prod_r  <= prod_nxt;
      n_r     <= n_nxt;
      m_r     <= m_nxt;
      s_r     <= s_nxt;
      shv_r   <= shv_nxt;
      rb_r    <= rb_nxt;
      fmax_r  <= fmax_nxt;
      fzero_r <= fzero_nxt;
      delta_r <= delta_nxt;
      res_r   <= res_nxt;
      sat_r   <= sat_nxt;
    end
  end

  // ---------------- output register and skid buffer ----------------
  logic               out_valid_r, out_sat_r, skid_sat_r;
  logic signed [31:0] out_scaled_r, skid_res_r;
  logic               take;

  assign take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= skid_full_r || vres_r;
      skid_full_r <= 1'b0;
    end else if (vres_r && adv) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_scaled_r <= skid_full_r ? skid_res_r : res_r;
      out_sat_r    <= skid_full_r ? skid_sat_r : sat_r;
    end else if (vres_r && adv) begin
      skid_res_r <= res_r;
      skid_sat_r <= sat_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scaled    = out_scaled_r;
  assign out_saturated = out_sat_r;

`ifndef NO_ASSERTIONS
  // a parked item in the skid buffer implies one is on the output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid buffer full with no output item");

  // a parked item stays while the output is stalled
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_full_r && out_stall) |=> skid_full_r)
    else $error("skid buffer lost an item under stall");

  // the saturation flag only comes with a rail value
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |->
      (out_scaled_r == 32'sh7FFF_FFFF || out_scaled_r == 32'sh8000_0000))
    else $error("saturated flag without a clipped value");

  // reset leaves no result on the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !skid_full_r))
    else $error("output valid right after reset");
`endif

endmodule
